/* hw/rtl/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg
// shared widths, character codes, scanner state type and output word type for
// the comment and indent stripper
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  typedef enum logic [4:0] {
    ST_NORMAL     = 5'b00001,
    ST_SLASH      = 5'b00010,
    ST_LINE       = 5'b00100,
    ST_BLOCK      = 5'b01000,
    ST_BLOCK_STAR = 5'b10000
  } scan_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              last;
  } out_word_t;

endpackage

/* hw/rtl/comment_and_indent_stripper.sv */
// ----------------------------------------------------------------------------
// comment_and_indent_stripper
// removes c style comments and, optionally, leading blanks of each line
// ----------------------------------------------------------------------------
// One text byte is taken per cycle on in_*; each byte yields zero, one or two
// bytes on out_*, the last of them flagged by out_tlast. Scanning and blank
// filtering finish in the cycle a byte is accepted and land in a two-entry
// output buffer, so bytes flow at one per cycle while out_tready is high; a
// byte that releases two words (a held slash plus the byte after it) holds
// in_tready low until the buffer has passed on the first of its two words.
// The leading blank filter is enabled by cfg_data (reset 1); the user must
// write it only while the block is idle, as the block does not enforce this.
// A slash still held at the end of the text is never released.
module comment_and_indent_stripper (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,    // strip_leading_blanks
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cis_pkg::CHAR_W-1:0] in_tdata,    // char_in
  // output stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cis_pkg::CHAR_W-1:0] out_tdata,   // char_out
  output logic                       out_tlast    // last_of_run
);

  cis_pkg::scan_state_t state_r, state_nxt;
  logic                 als_r, als_nxt;
  logic                 strip_r;
  cis_pkg::out_word_t   q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  logic                       in_acc, out_acc;
  logic                       e0_v, e1_v, k0, k1;
  logic [cis_pkg::CHAR_W-1:0] e0_d, e1_d;
  logic                       als_mid;
  logic                       blank0, blank1;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = q0_r.data;
  assign out_tlast  = q0_r.last;

  // comment scanner
  always_comb begin
    state_nxt = state_r;
    e0_v      = 1'b0;
    e0_d      = in_tdata;
    e1_v      = 1'b0;
    e1_d      = in_tdata;
    case (state_r)
      cis_pkg::ST_SLASH: begin
        if (in_tdata == cis_pkg::CH_SLASH) begin
          state_nxt = cis_pkg::ST_LINE;
        end else if (in_tdata == cis_pkg::CH_STAR) begin
          state_nxt = cis_pkg::ST_BLOCK;
        end else begin
          state_nxt = cis_pkg::ST_NORMAL;
          e0_v      = 1'b1;
          e0_d      = cis_pkg::CH_SLASH;
          e1_v      = 1'b1;
        end
      end
      cis_pkg::ST_LINE: begin
        if (in_tdata == cis_pkg::CH_NEWLINE) begin
          state_nxt = cis_pkg::ST_NORMAL;
          e0_v      = 1'b1;
        end
      end
      cis_pkg::ST_BLOCK: begin
        if (in_tdata == cis_pkg::CH_STAR) begin
          state_nxt = cis_pkg::ST_BLOCK_STAR;
        end
      end
      cis_pkg::ST_BLOCK_STAR: begin
        if (in_tdata == cis_pkg::CH_SLASH) begin
          state_nxt = cis_pkg::ST_NORMAL;
        end else if (in_tdata != cis_pkg::CH_STAR) begin
          state_nxt = cis_pkg::ST_BLOCK;
        end
      end
      default: begin
        if (in_tdata == cis_pkg::CH_SLASH) begin
          state_nxt = cis_pkg::ST_SLASH;
        end else begin
          state_nxt = cis_pkg::ST_NORMAL;
          e0_v      = 1'b1;
        end
      end
    endcase
  end

  // leading blank filter, first word then second
  always_comb begin
    blank0  = (e0_d == cis_pkg::CH_SPACE) || (e0_d == cis_pkg::CH_TAB);
    blank1  = (e1_d == cis_pkg::CH_SPACE) || (e1_d == cis_pkg::CH_TAB);
    als_mid = als_r;
    k0      = 1'b0;
    if (e0_v) begin
      k0 = !(blank0 && als_r && strip_r);
      if (e0_d == cis_pkg::CH_NEWLINE) begin
        als_mid = 1'b1;
      end else if (!blank0) begin
        als_mid = 1'b0;
      end
    end
    als_nxt = als_mid;
    k1      = 1'b0;
    if (e1_v) begin
      k1 = !(blank1 && als_mid && strip_r);
      if (e1_d == cis_pkg::CH_NEWLINE) begin
        als_nxt = 1'b1;
      end else if (!blank1) begin
        als_nxt = 1'b0;
      end
    end
  end

  // output buffer
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      if (k0) begin
        q0_nxt.data = e0_d;
        q0_nxt.last = !k1;
        q1_nxt.data = e1_d;
        q1_nxt.last = 1'b1;
      end else begin
        q0_nxt.data = e1_d;
        q0_nxt.last = 1'b1;
      end
      cnt_nxt = {1'b0, k0} + {1'b0, k1};
    end else if (out_acc) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cis_pkg::ST_NORMAL;
      als_r   <= 1'b1;
      strip_r <= 1'b1;
      cnt_r   <= 2'd0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
        als_r   <= als_nxt;
      end
      if (cfg_valid) begin
        strip_r <= cfg_data;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

/* hw/rtl/cis_checker.sv */
// ----------------------------------------------------------------------------
// cis_checker
// port level checks for the comment and indent stripper
// ----------------------------------------------------------------------------
module cis_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cis_pkg::CHAR_W-1:0] out_tdata,
  input logic                       out_tlast
);

  // no word is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // input only stalls while words are pending
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // a run's second word follows its first
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("run ended without last word");

  // a pending pair blocks new input
  a_pair_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while two words pending");

endmodule

bind comment_and_indent_stripper cis_checker u_cis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* bench/stripped_text_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stripped_text_checker
// Follows every byte taken on the input stream and every write to the
// leading blank enable. It works out which bytes the stripper must release
// and queues them. Each word on the output stream is matched in order
// against that queue. Mismatches and unexpected words are counted for the
// top, which also sees how many words are still owed.
// ----------------------------------------------------------------------------
module stripped_text_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [cis_pkg::CHAR_W-1:0] in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [cis_pkg::CHAR_W-1:0] out_tdata,
  input  logic                       out_tlast,
  output int                         fail_count,
  output int                         words_due
);

  cis_pkg::scan_state_t scan_st;
  logic                 line_start;
  logic                 strip_en;
  cis_pkg::out_word_t   kept_words_q[$];
  cis_pkg::out_word_t   step_words[2];
  int                   n_step;
  int                   mismatches = 0;
  int                   due_cnt = 0;

  assign fail_count = mismatches;
  assign words_due  = due_cnt;

  // leading blank stage
  function automatic void pass_blank(input logic [cis_pkg::CHAR_W-1:0] c);
    logic keep;
    keep = 1'b1;
    if (c == cis_pkg::CH_NEWLINE) begin
      line_start = 1'b1;
    end else if (c == cis_pkg::CH_SPACE || c == cis_pkg::CH_TAB) begin
      if (line_start && strip_en) begin
        keep = 1'b0;
      end
    end else begin
      line_start = 1'b0;
    end
    if (keep) begin
      step_words[n_step].data = c;
      step_words[n_step].last = 1'b0;
      n_step++;
    end
  endfunction

  // comment stage, queues the words one byte releases
  function automatic void scan_char(input logic [cis_pkg::CHAR_W-1:0] c);
    n_step = 0;
    case (scan_st)
      cis_pkg::ST_SLASH: begin
        if (c == cis_pkg::CH_SLASH) begin
          scan_st = cis_pkg::ST_LINE;
        end else if (c == cis_pkg::CH_STAR) begin
          scan_st = cis_pkg::ST_BLOCK;
        end else begin
          scan_st = cis_pkg::ST_NORMAL;
          pass_blank(cis_pkg::CH_SLASH);
          pass_blank(c);
        end
      end
      cis_pkg::ST_LINE: begin
        if (c == cis_pkg::CH_NEWLINE) begin
          scan_st = cis_pkg::ST_NORMAL;
          pass_blank(c);
        end
      end
      cis_pkg::ST_BLOCK: begin
        if (c == cis_pkg::CH_STAR) begin
          scan_st = cis_pkg::ST_BLOCK_STAR;
        end
      end
      cis_pkg::ST_BLOCK_STAR: begin
        if (c == cis_pkg::CH_SLASH) begin
          scan_st = cis_pkg::ST_NORMAL;
        end else if (c != cis_pkg::CH_STAR) begin
          scan_st = cis_pkg::ST_BLOCK;
        end
      end
      default: begin
        if (c == cis_pkg::CH_SLASH) begin
          scan_st = cis_pkg::ST_SLASH;
        end else begin
          scan_st = cis_pkg::ST_NORMAL;
          pass_blank(c);
        end
      end
    endcase
    if (n_step > 0) begin
      step_words[n_step-1].last = 1'b1;
    end
    for (int i = 0; i < n_step; i++) begin
      kept_words_q.insert(kept_words_q.size(), step_words[i]);
    end
  endfunction

  always @(posedge clk) begin
    cis_pkg::out_word_t want;
    if (!rst_n) begin
      strip_en   = 1'b1;
      scan_st    = cis_pkg::ST_NORMAL;
      line_start = 1'b1;
      kept_words_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        strip_en = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        scan_char(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (kept_words_q.size() == 0) begin
          $error("unexpected word: char_out %02h last_of_run %0b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = kept_words_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("char_out mismatch: expected %02h, actual %02h", want.data, out_tdata);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    due_cnt <= kept_words_q.size();
  end

endmodule

/* bench/comment_and_indent_stripper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_and_indent_stripper_tb
// Feeds the stripper C-like text: line and block comments, star runs, lone
// slashes, indented lines and raw noise bytes, under every setting of the
// leading blank enable. Both streams idle at random; the receiver also holds
// off for a long stretch so the block backs up. The checker beside the block
// predicts and compares every word.
// ----------------------------------------------------------------------------
module comment_and_indent_stripper_tb;

  localparam int TEXT_ITEMS = 850;
  localparam int N_PHASES   = 6;
  localparam int SETTLE_CYC = 4;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_data;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [cis_pkg::CHAR_W-1:0] in_tdata;   // char_in
  logic                       out_tvalid;
  logic                       out_tready;
  logic [cis_pkg::CHAR_W-1:0] out_tdata;  // char_out
  logic                       out_tlast;  // last_of_run
  int                         fail_count;
  int                         words_due;

  bit quiet;
  bit hold_off_req;
  int text_sent;

  comment_and_indent_stripper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  stripped_text_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("comment_and_indent_stripper_tb NOT OK");
    $finish;
  end

  // receiver
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [cis_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0: return cis_pkg::CH_SLASH;
      1: return cis_pkg::CH_STAR;
      2: return cis_pkg::CH_NEWLINE;
      3: return cis_pkg::CH_SPACE;
      4: return cis_pkg::CH_TAB;
      5, 6: return 8'($urandom_range(8'h61, 8'h7a));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_char(input logic [cis_pkg::CHAR_W-1:0] c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    text_sent++;
  endtask

  task automatic send_text(input logic [cis_pkg::CHAR_W-1:0] c);
    send_char(c);
  endtask

  // stop offering and wait until every owed word has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_strip(input logic en);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_chunk();
    int                         len;
    logic [cis_pkg::CHAR_W-1:0] c;
    len = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0, 1: begin
        send_text(cis_pkg::CH_SLASH);
        send_char(cis_pkg::CH_SLASH);
        repeat (len) begin
          do c = pick_char(); while (c == cis_pkg::CH_NEWLINE);
          send_char(c);
        end
        send_text(cis_pkg::CH_NEWLINE);
      end
      2, 3: begin
        send_text(cis_pkg::CH_SLASH);
        send_char(cis_pkg::CH_STAR);
        repeat (len) send_char(pick_char());
        if ($urandom_range(0, 1)) begin
          send_char(cis_pkg::CH_STAR);
        end
        send_char(cis_pkg::CH_STAR);
        send_text(cis_pkg::CH_SLASH);
      end
      4, 5: begin
        repeat (len) send_text($urandom_range(0, 1) ? cis_pkg::CH_SPACE : cis_pkg::CH_TAB);
        repeat ($urandom_range(1, 5)) send_text(pick_char());
        if ($urandom_range(0, 1)) begin
          send_text(cis_pkg::CH_NEWLINE);
        end
      end
      6: begin
        repeat ($urandom_range(1, 3)) send_text(cis_pkg::CH_NEWLINE);
      end
      7: begin
        send_text(cis_pkg::CH_SLASH);
        send_text(pick_char());
      end
      default: begin
        repeat (len + 1) send_text(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    string s;
    logic  en;
    int    phase_end;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    text_sent    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blanks, byte extremes, held slash, line and block comments, star runs,
    // slash before newline, and a slash left pending into the next phase
    s = " \t";
    for (int i = 0; i < s.len(); i++) send_text(s[i]);
    send_text(8'h00);
    send_text(8'hFF);
    s = "\n a/b//c\n\t/**q*z**/x/\n/";
    for (int i = 0; i < s.len(); i++) send_text(s[i]);
    text_sent = 0;

    for (int p = 0; p < N_PHASES; p++) begin
      en = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      write_strip(en);
      phase_end = (p + 1) * TEXT_ITEMS / N_PHASES;
      if (p == 2) begin
        hold_off_req = 1'b1;
        quiet        = 1'b1;
        repeat (20) send_chunk();
      end
      while (text_sent < phase_end) begin
        quiet = ($urandom_range(0, 4) == 0);
        send_chunk();
        if (p == 3 && text_sent >= phase_end - TEXT_ITEMS / (2 * N_PHASES)
            && text_sent < phase_end - TEXT_ITEMS / (2 * N_PHASES) + 8) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("comment_and_indent_stripper_tb OK");
    end else begin
      $display("comment_and_indent_stripper_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cis_pkg.sv
hw/rtl/comment_and_indent_stripper.sv
hw/rtl/cis_checker.sv
bench/stripped_text_checker.sv
bench/comment_and_indent_stripper_tb.sv
